/* design/gspe_pkg.sv */
// ----------------------------------------------------------------------------
// gspe_pkg
// Shared types, field widths and codes for the shortest-path engine.
// ----------------------------------------------------------------------------
package gspe_pkg;

   localparam int unsigned MAX_VERTICES_DEF = 64;
   localparam int unsigned MAX_EDGES_DEF    = 256;

   localparam int unsigned VC_W   = 7;
   localparam int unsigned VTX_W  = 6;
   localparam int unsigned WGT_W  = 32;
   localparam int unsigned DIST_W = 40;
   localparam int unsigned ACT_W  = 2;
   localparam int unsigned ST_W   = 2;

   localparam logic [VC_W-1:0]   VC_RESET     = 7'd64;
   localparam logic [DIST_W-1:0] DIST_UNKNOWN = 40'hFF_FFFF_FFFF;
   localparam logic [DIST_W-1:0] DIST_SAT     = 40'hFF_FFFF_FFFE;

   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
   localparam logic [ACT_W-1:0] ACT_ADD   = 2'd1;
   localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
   localparam logic [ST_W-1:0] ST_UNREACH = 2'd2;
   localparam logic [ST_W-1:0] ST_RANGE   = 2'd3;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [VTX_W-1:0] vertex_a;
      logic [VTX_W-1:0] vertex_b;
      logic [WGT_W-1:0] edge_weight;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic [VTX_W-1:0]  path_vertex;
      logic [DIST_W-1:0] path_distance;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [WGT_W-1:0] weight;
      logic [VTX_W-1:0] vertex_b;
      logic [VTX_W-1:0] vertex_a;
   } edge_type;

   typedef struct packed {
      logic latch;
      logic exec_single;
      logic init_query;
      logic scan_init;
      logic scan_step;
      logic settle;
      logic edge_rd;
      logic edge_dist;
      logic edge_upd;
      logic walk_init;
      logic walk_step;
      logic walk_load;
      logic emit_rd;
      logic out_single;
      logic out_unreach;
      logic out_path;
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             range_bad;
      logic             scan_done;
      logic             found;
      logic             best_is_target;
      logic             edge_more;
      logic             walk_more;
      logic             emit_last;
      logic             out_free;
   } stat_type;

endpackage

/* design/graph_shortest_path_engine.sv */
// ----------------------------------------------------------------------------
// graph_shortest_path_engine
// Dijkstra shortest-path engine over a loaded undirected weighted graph.
//
//   Port group   Direction  Handshake       Word
//   req_*        in         valid/ready     action, vertices, edge weight
//   rsp_*        out        valid/ready     status, path vertex, distance, last
//   csr_*        in         write enable    vertex count
//
// A clear or add passes through the latch, decode and single-word states. A query
// runs, per settled vertex, the minimum scan over the distance table, the settle
// step and a relaxation of each stored edge, then walks back the parent table per
// path vertex and emits one word per path vertex. Reset is synchronous
// and needs no clearing pass. A stalled result word holds; a new request is
// taken once the sequencer is back in idle, even while the last word waits.
// ----------------------------------------------------------------------------
module graph_shortest_path_engine #(
   parameter int unsigned MAX_VERTICES = gspe_pkg::MAX_VERTICES_DEF,
   parameter int unsigned MAX_EDGES    = gspe_pkg::MAX_EDGES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  gspe_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output gspe_pkg::rsp_type         rsp_data,
   input  logic                      csr_we,
   input  logic [gspe_pkg::VC_W-1:0] csr_wdata
);
   import gspe_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   gspe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   gspe_dp #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* design/gspe_ctrl.sv */
// ----------------------------------------------------------------------------
// gspe_ctrl
// Sequencer for loads, queries, path walk-back and word emission.
// ----------------------------------------------------------------------------
module gspe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  gspe_pkg::stat_type stat,
   output gspe_pkg::cmd_type  cmd
);
   import gspe_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DECODE    = 4'd1;
   localparam logic [3:0] S_SINGLE    = 4'd2;
   localparam logic [3:0] S_SCAN_INIT = 4'd3;
   localparam logic [3:0] S_SCAN      = 4'd4;
   localparam logic [3:0] S_EDGE      = 4'd5;
   localparam logic [3:0] S_EDGE_D    = 4'd6;
   localparam logic [3:0] S_EDGE_U    = 4'd7;
   localparam logic [3:0] S_UNREACH   = 4'd8;
   localparam logic [3:0] S_WALK_INIT = 4'd9;
   localparam logic [3:0] S_WALK      = 4'd10;
   localparam logic [3:0] S_WALK_W    = 4'd11;
   localparam logic [3:0] S_EMIT_RD   = 4'd12;
   localparam logic [3:0] S_EMIT      = 4'd13;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.action == ACT_CLEAR || stat.action == ACT_ADD) begin
               state_in = S_SINGLE;
            end else if (stat.action == ACT_QUERY) begin
               if (stat.range_bad) begin
                  state_in = S_SINGLE;
               end else begin
                  cmd.init_query = 1'b1;
                  state_in       = S_SCAN_INIT;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SINGLE: begin
            if (stat.out_free) begin
               cmd.out_single  = 1'b1;
               cmd.exec_single = (stat.action == ACT_CLEAR) || (stat.action == ACT_ADD);
               state_in        = S_IDLE;
            end
         end
         S_SCAN_INIT: begin
            cmd.scan_init = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            if (!stat.scan_done) begin
               cmd.scan_step = 1'b1;
            end else if (!stat.found) begin
               state_in = S_UNREACH;
            end else if (stat.best_is_target) begin
               state_in = S_WALK_INIT;
            end else begin
               cmd.settle = 1'b1;
               state_in   = S_EDGE;
            end
         end
         S_EDGE: begin
            if (stat.edge_more) begin
               cmd.edge_rd = 1'b1;
               state_in    = S_EDGE_D;
            end else begin
               state_in = S_SCAN_INIT;
            end
         end
         S_EDGE_D: begin
            cmd.edge_dist = 1'b1;
            state_in      = S_EDGE_U;
         end
         S_EDGE_U: begin
            cmd.edge_upd = 1'b1;
            state_in     = S_EDGE;
         end
         S_UNREACH: begin
            if (stat.out_free) begin
               cmd.out_unreach = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_WALK_INIT: begin
            cmd.walk_init = 1'b1;
            state_in      = S_WALK;
         end
         S_WALK: begin
            if (stat.walk_more) begin
               cmd.walk_step = 1'b1;
               state_in      = S_WALK_W;
            end else begin
               state_in = S_EMIT_RD;
            end
         end
         S_WALK_W: begin
            cmd.walk_load = 1'b1;
            state_in      = S_WALK;
         end
         S_EMIT_RD: begin
            cmd.emit_rd = 1'b1;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.out_path = 1'b1;
               state_in     = stat.emit_last ? S_IDLE : S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/gspe_dp.sv */
// ----------------------------------------------------------------------------
// gspe_dp
// Datapath: edge store, distance and parent tables, minimum scan, edge
// relaxation, path buffer and the result word register.
// ----------------------------------------------------------------------------
module gspe_dp #(
   parameter int unsigned MAX_VERTICES = gspe_pkg::MAX_VERTICES_DEF,
   parameter int unsigned MAX_EDGES    = gspe_pkg::MAX_EDGES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gspe_pkg::req_type          req_data,
   input  logic                       csr_we,
   input  logic [gspe_pkg::VC_W-1:0]  csr_wdata,
   input  gspe_pkg::cmd_type          cmd,
   output gspe_pkg::stat_type         stat,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output gspe_pkg::rsp_type          rsp_data
);
   import gspe_pkg::*;

   localparam int unsigned VW  = $clog2(MAX_VERTICES);
   localparam int unsigned CW  = $clog2(MAX_VERTICES + 1);
   localparam int unsigned PW  = VW + 1;
   localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
   localparam logic [PW-1:0]   PARENT_NONE = '1;
   localparam logic [VC_W-1:0] MAXV_VC     = VC_W'(MAX_VERTICES);
   localparam logic [CW-1:0]   MAXV_C      = CW'(MAX_VERTICES);
   localparam logic [PW-1:0]   MAXV_P      = PW'(MAX_VERTICES);
   localparam logic [ECW-1:0]  MAXE_C      = ECW'(MAX_EDGES);

   req_type            req_ff;
   logic [VC_W-1:0]    vc_ff;
   logic [ECW-1:0]     ecnt_ff;
   edge_type           edge_mem_ff [MAX_EDGES];
   edge_type           edge_rd_ff;
   logic [DIST_W-1:0]  dist_mem_ff [MAX_VERTICES];
   logic [DIST_W-1:0]  dist_rd_ff;
   logic [PW-1:0]      par_mem_ff [MAX_VERTICES];
   logic [PW-1:0]      par_rd_ff;
   logic [VW-1:0]      buf_mem_ff [MAX_VERTICES];
   logic [VW-1:0]      buf_rd_ff;
   logic [MAX_VERTICES-1:0] dval_ff;
   logic [MAX_VERTICES-1:0] setl_ff;
   logic [CW-1:0]      vi_ff;
   logic               pv_ff;
   logic [VW-1:0]      pidx_ff;
   logic               found_ff;
   logic [VW-1:0]      best_ff;
   logic [DIST_W-1:0]  bd_ff;
   logic [ECW-1:0]     ei_ff;
   logic [VW-1:0]      oth_ff;
   logic [DIST_W-1:0]  nd_ff;
   logic               upd_ok_ff;
   logic [PW-1:0]      at_ff;
   logic [CW-1:0]      len_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic [VC_W-1:0]    n_vc;
   logic [CW-1:0]      n_c;
   logic               range_bad;
   logic               full;
   logic [VTX_W-1:0]   best_v;
   logic               match_a;
   logic               match_b;
   logic [VTX_W-1:0]   other_v;
   logic               stale;
   logic [DIST_W:0]    sum;
   logic [DIST_W-1:0]  nd;
   logic               scan_rd;
   logic [VW-1:0]      dist_raddr;
   logic               cand;
   logic               better;
   logic [CW-1:0]      emit_idx;
   logic               out_free;
   logic [ST_W-1:0]    single_st;
   logic [VW-1:0]      va_i;
   logic               add_ok;

   assign n_vc      = (vc_ff > MAXV_VC) ? MAXV_VC : vc_ff;
   assign n_c       = n_vc[CW-1:0];
   assign range_bad = ({1'b0, req_ff.vertex_a} >= n_vc) || ({1'b0, req_ff.vertex_b} >= n_vc);
   assign full      = (ecnt_ff >= MAXE_C);
   assign add_ok    = !range_bad && !full;
   assign va_i      = req_ff.vertex_a[VW-1:0];

   assign best_v  = VTX_W'(best_ff);
   assign match_a = (edge_rd_ff.vertex_a == best_v);
   assign match_b = (edge_rd_ff.vertex_b == best_v);
   assign other_v = match_a ? edge_rd_ff.vertex_b : edge_rd_ff.vertex_a;
   assign stale   = ({1'b0, edge_rd_ff.vertex_a} >= n_vc) || ({1'b0, edge_rd_ff.vertex_b} >= n_vc);
   assign sum     = (DIST_W+1)'(bd_ff) + (DIST_W+1)'(edge_rd_ff.weight);
   assign nd      = (sum > (DIST_W+1)'(DIST_SAT)) ? DIST_SAT : sum[DIST_W-1:0];

   assign scan_rd    = cmd.scan_step && (vi_ff < n_c);
   assign dist_raddr = cmd.edge_dist ? other_v[VW-1:0] : vi_ff[VW-1:0];
   assign cand       = pv_ff && dval_ff[pidx_ff] && !setl_ff[pidx_ff] &&
                       (!found_ff || (dist_rd_ff < bd_ff));
   assign better     = upd_ok_ff && (!dval_ff[oth_ff] || (nd_ff < dist_rd_ff));
   assign emit_idx   = len_ff - CW'(1);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      unique case (req_ff.action)
         ACT_CLEAR: single_st = ST_OK;
         ACT_ADD:   single_st = range_bad ? ST_RANGE : (full ? ST_FULL : ST_OK);
         default:   single_st = ST_RANGE;
      endcase
   end

   always_comb begin
      stat.action         = req_ff.action;
      stat.range_bad      = range_bad;
      stat.scan_done      = (vi_ff == n_c) && !pv_ff;
      stat.found          = found_ff;
      stat.best_is_target = (best_v == req_ff.vertex_b);
      stat.edge_more      = (ei_ff < ecnt_ff);
      stat.walk_more      = (at_ff < MAXV_P) && (len_ff < MAXV_C);
      stat.emit_last      = (len_ff == CW'(1));
      stat.out_free       = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff        <= VC_RESET;
         ecnt_ff      <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            vc_ff <= csr_wdata;
         end
         if (cmd.exec_single) begin
            if (req_ff.action == ACT_CLEAR) begin
               ecnt_ff <= '0;
            end else if (add_ok) begin
               ecnt_ff <= ecnt_ff + ECW'(1);
            end
         end
         if (cmd.scan_init) begin
            pv_ff <= 1'b0;
         end else if (cmd.scan_step) begin
            pv_ff <= scan_rd;
         end
         if (cmd.out_single || cmd.out_unreach || cmd.out_path) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_data;
      end
      if (cmd.init_query) begin
         dval_ff <= MAX_VERTICES'(1) << va_i;
         setl_ff <= '0;
      end else begin
         if (cmd.edge_upd && better) begin
            dval_ff[oth_ff] <= 1'b1;
         end
         if (cmd.settle) begin
            setl_ff[best_ff] <= 1'b1;
         end
      end
      if (cmd.scan_init) begin
         vi_ff    <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         if (scan_rd) begin
            vi_ff <= vi_ff + CW'(1);
         end
         pidx_ff <= vi_ff[VW-1:0];
      end
      if (cand) begin
         found_ff <= 1'b1;
         best_ff  <= pidx_ff;
         bd_ff    <= dist_rd_ff;
      end
      if (cmd.settle) begin
         ei_ff <= '0;
      end else if (cmd.edge_dist) begin
         ei_ff <= ei_ff + ECW'(1);
      end
      if (cmd.edge_dist) begin
         oth_ff    <= other_v[VW-1:0];
         nd_ff     <= nd;
         upd_ok_ff <= (match_a || match_b) && !stale;
      end
      if (cmd.walk_init) begin
         at_ff  <= PW'(req_ff.vertex_b);
         len_ff <= '0;
      end else if (cmd.walk_load) begin
         at_ff <= par_rd_ff;
      end else if (cmd.walk_step) begin
         len_ff <= len_ff + CW'(1);
      end else if (cmd.out_path) begin
         len_ff <= emit_idx;
      end
      if (cmd.out_single) begin
         rsp_ff.status        <= single_st;
         rsp_ff.path_vertex   <= '0;
         rsp_ff.path_distance <= '0;
         rsp_ff.last          <= 1'b1;
      end else if (cmd.out_unreach) begin
         rsp_ff.status        <= ST_UNREACH;
         rsp_ff.path_vertex   <= '0;
         rsp_ff.path_distance <= DIST_UNKNOWN;
         rsp_ff.last          <= 1'b1;
      end else if (cmd.out_path) begin
         rsp_ff.status        <= ST_OK;
         rsp_ff.path_vertex   <= VTX_W'(buf_rd_ff);
         rsp_ff.path_distance <= bd_ff;
         rsp_ff.last          <= (len_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec_single && req_ff.action == ACT_ADD && add_ok) begin
         edge_mem_ff[ecnt_ff[EAW-1:0]] <= '{weight:   req_ff.edge_weight,
                                           vertex_b: req_ff.vertex_b,
                                           vertex_a: req_ff.vertex_a};
      end
      if (cmd.edge_rd) begin
         edge_rd_ff <= edge_mem_ff[ei_ff[EAW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_query) begin
         dist_mem_ff[va_i] <= '0;
      end else if (cmd.edge_upd && better) begin
         dist_mem_ff[oth_ff] <= nd_ff;
      end
      if (scan_rd || cmd.edge_dist) begin
         dist_rd_ff <= dist_mem_ff[dist_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_query) begin
         par_mem_ff[va_i] <= PARENT_NONE;
      end else if (cmd.edge_upd && better) begin
         par_mem_ff[oth_ff] <= PW'(best_ff);
      end
      if (cmd.walk_step) begin
         par_rd_ff <= par_mem_ff[at_ff[VW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_step) begin
         buf_mem_ff[len_ff[VW-1:0]] <= at_ff[VW-1:0];
      end
      if (cmd.emit_rd) begin
         buf_rd_ff <= buf_mem_ff[emit_idx[VW-1:0]];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* design/gspe_checker.sv */
// ----------------------------------------------------------------------------
// gspe_checker
// Port-level checks for the shortest-path engine, bound to the top level.
// ----------------------------------------------------------------------------
module gspe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input gspe_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input gspe_pkg::rsp_type rsp_data
);
   import gspe_pkg::*;

   // A stalled result word must hold.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // The sequencer is out of idle in the cycle after it takes a word.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken back to back");

   // Only the final word of a path may carry a non-ok status.
   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.status == ST_OK)
      else $error("non-final word with error status");

   // An unreachable target reports the unknown distance.
   a_unreach_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_UNREACH |->
         rsp_data.path_distance == DIST_UNKNOWN && rsp_data.last)
      else $error("unreachable word without unknown distance");

endmodule

bind graph_shortest_path_engine gspe_checker u_gspe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
